/* hdl/cng_pkg.sv */
// Shared types, codes and helpers for the node-guard supervisor.
// No dependencies; every other file in hdl depends on this package.
`default_nettype none

package cng_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam logic [10:0] GuardBaseId   = 11'h700;
  localparam logic [6:0]  NmtStopped    = 7'h04;
  localparam logic [6:0]  NmtOperational = 7'h05;
  localparam logic [6:0]  NmtPreop      = 7'h7F;
  localparam logic [15:0] AgeMax        = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_GUARD = 2'd1,
    OP_STATE = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_GUARD = 2'd1,
    CMD_START = 2'd2,
    CMD_RESET = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    LINK_UNKNOWN = 3'd0,
    LINK_STOPPED = 3'd1,
    LINK_PREOP   = 3'd2,
    LINK_OPER    = 3'd3,
    LINK_FAULT   = 3'd4
  } link_t;

  typedef enum logic [2:0] {
    NODE_INIT  = 3'b001,
    NODE_READY = 3'b010,
    NODE_EMERG = 3'b100
  } node_state_t;

  localparam logic [1:0] NodeCodeInit  = 2'd0;
  localparam logic [1:0] NodeCodeReady = 2'd1;
  localparam logic [1:0] NodeCodeEmerg = 2'd2;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_NODE_ID       = 3'd0,
    CFG_PDO1_BASE     = 3'd1,
    CFG_PDO2_BASE     = 3'd2,
    CFG_GUARD_TIMEOUT = 3'd3,
    CFG_RECOVER_PERIOD = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [6:0]  node_id;
    logic [10:0] pdo1_base;
    logic [10:0] pdo2_base;
    logic [15:0] guard_timeout_ticks;
    logic [15:0] recover_period;
  } cng_cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [10:0] frame_id;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
  } cng_item_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  link_status;
    logic [1:0]  node_state;
    logic [15:0] count_value;
  } cng_result_t;

  // Maps the one-hot machine state onto the code reported in a result item.
  function automatic logic [1:0] node_code(node_state_t s);
    logic [1:0] code;
    code = NodeCodeInit;
    case (s)
      NODE_INIT:  code = NodeCodeInit;
      NODE_READY: code = NodeCodeReady;
      NODE_EMERG: code = NodeCodeEmerg;
      default:    code = NodeCodeInit;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* hdl/cng_if.sv */
// Handshake channel interfaces: input item, result item and register write.
// Depends on cng_pkg for the register index width; payload widths follow the fields.
`default_nettype none

interface cng_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [10:0] frame_id;
  logic [7:0]  data_byte0;
  logic [7:0]  data_byte1;

  modport source (output valid, opcode, frame_id, data_byte0, data_byte1, input ready);
  modport sink   (input valid, opcode, frame_id, data_byte0, data_byte1, output ready);
endinterface

interface cng_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  link_status;
  logic [1:0]  node_state;
  logic [15:0] count_value;

  modport source (output valid, command, link_status, node_state, count_value, input ready);
  modport sink   (input valid, command, link_status, node_state, count_value, output ready);
endinterface

interface cng_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cng_pkg::CfgIndexWidth-1:0] index;
  logic [15:0]                      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/cng_cfg_regs.sv */
// Configuration register bank written through the register write channel.
// Depends on cng_pkg for the register indexes and the settings struct.
`default_nettype none

module cng_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [cng_pkg::CfgIndexWidth-1:0] wr_index,
  input  logic [15:0]                       wr_data,
  output cng_pkg::cng_cfg_t                 cfg
);
  import cng_pkg::*;

  cng_cfg_t cfg_r;
  cng_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_index_t'(wr_index))
        CFG_NODE_ID:        cfg_nxt.node_id             = wr_data[6:0];
        CFG_PDO1_BASE:      cfg_nxt.pdo1_base           = wr_data[10:0];
        CFG_PDO2_BASE:      cfg_nxt.pdo2_base           = wr_data[10:0];
        CFG_GUARD_TIMEOUT:  cfg_nxt.guard_timeout_ticks = wr_data;
        CFG_RECOVER_PERIOD: cfg_nxt.recover_period      = wr_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_id             <= 7'd1;
      cfg_r.pdo1_base           <= 11'd384;
      cfg_r.pdo2_base           <= 11'd640;
      cfg_r.guard_timeout_ticks <= 16'd15;
      cfg_r.recover_period      <= 16'd40;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* hdl/cng_engine.sv */
// Supervisor state and the single-pass update applied to one item.
// Depends on cng_pkg for codes, the item, settings and result structs.
`default_nettype none

module cng_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  cng_pkg::cng_item_t   item,
  input  cng_pkg::cng_cfg_t    cfg,
  output cng_pkg::cng_result_t result
);
  import cng_pkg::*;

  link_t       link_r,    link_nxt;
  node_state_t node_r,    node_nxt;
  logic [15:0] count_r,   count_nxt;
  logic [15:0] age_r,     age_nxt;
  logic [15:0] recover_r, recover_nxt;
  cmd_t        cmd;

  logic [10:0] guard_id;
  logic [10:0] pdo1_id;
  logic [10:0] pdo2_id;
  logic        is_guard_reply;
  logic        is_pdo;
  logic [6:0]  nmt_state;
  logic [15:0] age_inc;

  assign guard_id       = GuardBaseId + {4'd0, cfg.node_id};
  assign pdo1_id        = cfg.pdo1_base + {4'd0, cfg.node_id};
  assign pdo2_id        = cfg.pdo2_base + {4'd0, cfg.node_id};
  assign is_guard_reply = (item.frame_id == guard_id);
  assign is_pdo         = (item.frame_id == pdo1_id) || (item.frame_id == pdo2_id);
  assign nmt_state      = item.data_byte0[6:0];
  assign age_inc        = (age_r == AgeMax) ? age_r : age_r + 16'd1;

  always_comb begin
    link_nxt    = link_r;
    node_nxt    = node_r;
    count_nxt   = count_r;
    age_nxt     = age_r;
    recover_nxt = recover_r;
    cmd         = CMD_NONE;
    case (opcode_t'(item.opcode))
      OP_FRAME: begin
        // A recognised reply state ends the frame; any other reply byte
        // still lets the identifier match a process data object.
        if (is_guard_reply) begin
          age_nxt = '0;
        end
        if (is_guard_reply && nmt_state == NmtStopped) begin
          link_nxt = LINK_STOPPED;
        end else if (is_guard_reply && nmt_state == NmtOperational) begin
          link_nxt = LINK_OPER;
        end else if (is_guard_reply && nmt_state == NmtPreop) begin
          link_nxt = LINK_PREOP;
        end else if (is_pdo) begin
          count_nxt = {item.data_byte1, item.data_byte0};
        end
      end
      OP_GUARD: begin
        cmd     = CMD_GUARD;
        age_nxt = age_inc;
        if (age_inc > cfg.guard_timeout_ticks) begin
          link_nxt = LINK_FAULT;
        end
      end
      OP_STATE: begin
        case (node_r)
          NODE_INIT: begin
            age_nxt = '0;
            if (link_r == LINK_FAULT) begin
              node_nxt = NODE_EMERG;
            end else if (link_r != LINK_OPER) begin
              cmd = CMD_START;
            end else begin
              node_nxt = NODE_READY;
            end
          end
          NODE_READY: begin
            if (link_r == LINK_FAULT) begin
              node_nxt = NODE_EMERG;
            end else if (link_r != LINK_OPER) begin
              node_nxt = NODE_INIT;
            end
          end
          NODE_EMERG: begin
            if (link_r != LINK_FAULT) begin
              node_nxt = NODE_INIT;
            end else if (recover_r == cfg.recover_period) begin
              recover_nxt = '0;
              cmd         = CMD_RESET;
            end else begin
              recover_nxt = recover_r + 16'd1;
            end
          end
          default: node_nxt = NODE_INIT;
        endcase
      end
      default: cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r    <= LINK_UNKNOWN;
      node_r    <= NODE_INIT;
      count_r   <= '0;
      age_r     <= '0;
      recover_r <= '0;
    end else if (step_en) begin
      link_r    <= link_nxt;
      node_r    <= node_nxt;
      count_r   <= count_nxt;
      age_r     <= age_nxt;
      recover_r <= recover_nxt;
    end
  end

  assign result.command     = cmd;
  assign result.link_status = link_nxt;
  assign result.node_state  = node_code(node_nxt);
  assign result.count_value = count_nxt;

endmodule

`default_nettype wire

/* hdl/canopen_node_guard_monitor.sv */
// Top level of the node-guard supervisor: input register, update engine,
// result register and configuration bank. Depends on cng_pkg, cng_if.sv,
// cng_cfg_regs and cng_engine.
`default_nettype none

// Accepts one item per clock unless the result register stalls, and returns exactly one result item for each.
// The item is captured in an input register, passes through one combinational
// update of the supervisor state and lands in the result register, from which
// its result is offered. While the result register is full and not taken, one
// further item waits in the input register before in_if.ready drops.
// Register writes are taken on any cycle and should be made while idle.
module canopen_node_guard_monitor (
  input  logic                clk,
  input  logic                rst_n,
  cng_item_if.sink            in_if,
  cng_result_if.source        out_if,
  cng_cfg_if.sink             cfg_if
);
  import cng_pkg::*;

  logic        in_vld_r;
  cng_item_t   in_item_r;
  logic        out_vld_r;
  cng_result_t out_res_r;
  cng_result_t step_res;
  cng_cfg_t    cfg;
  logic        advance;
  logic        in_take;

  assign advance   = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || advance;
  assign in_take   = in_if.valid && in_if.ready;

  assign cfg_if.ready = 1'b1;

  cng_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_if.valid),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .cfg      (cfg)
  );

  cng_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_vld_r <= in_if.valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.opcode     <= in_if.opcode;
      in_item_r.frame_id   <= in_if.frame_id;
      in_item_r.data_byte0 <= in_if.data_byte0;
      in_item_r.data_byte1 <= in_if.data_byte1;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.command     = out_res_r.command;
  assign out_if.link_status = out_res_r.link_status;
  assign out_if.node_state  = out_res_r.node_state;
  assign out_if.count_value = out_res_r.count_value;

`ifndef ASSERT_OFF
  // A reset command is only issued from emergency while the link is in fault.
  a_reset_cmd_in_emerg : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.command == CMD_RESET) |->
      (out_res_r.node_state == NodeCodeEmerg && out_res_r.link_status == LINK_FAULT))
    else $error("reset command outside emergency with fault");

  // A start command leaves the node in init with a link that is neither up nor faulted.
  a_start_cmd_in_init : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.command == CMD_START) |->
      (out_res_r.node_state == NodeCodeInit && out_res_r.link_status != LINK_OPER
       && out_res_r.link_status != LINK_FAULT))
    else $error("start command with inconsistent state");

  // A held item with a stalled result register must block further input.
  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_vld_r && !out_if.ready) |-> !in_if.ready)
    else $error("input accepted while both registers are full");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the CANopen node-guard supervisor.
// Depends on cng_pkg, the channel interfaces in cng_if.sv and the top level;
// a directed table comes first, then random phases under several register settings.
`timescale 1ns / 1ps

module testbench;
  import cng_pkg::*;

  typedef struct packed {
    bit          pinned;
    cng_result_t want;
  } fixed_t;

  typedef struct packed {
    cng_item_t   item;
    bit          pinned;
    cng_result_t want;
  } step_row_t;

  localparam int RandomPhases  = 6;
  localparam int PhaseItems    = 250;
  localparam int SecondSetRow  = 12;
  localparam int LongRunItems  = 40;
  localparam int DrainLimit    = 5000;

  logic clk;
  logic rst_n;

  cng_item_if   in_ch ();
  cng_result_if res_ch ();
  cng_cfg_if    cfg_ch ();

  canopen_node_guard_monitor DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (res_ch),
    .cfg_if (cfg_ch)
  );

  // Supervisor state and register bank as the testbench believes them to be.
  cng_cfg_t    cfg_now;
  link_t       link_now;
  logic [1:0]  node_now;
  logic [15:0] count_now;
  logic [15:0] reply_age_now;
  logic [15:0] recover_now;

  cng_result_t due_results [$];
  fixed_t      fixed_q [$];
  int          mismatches = 0;
  int          burst_left = 0;
  bit          squeeze_req = 1'b0;

  cng_result_t got_r;
  cng_result_t want_r;
  cng_result_t predicted_r;
  cng_item_t   taken_item;
  fixed_t      tag;

  // Directed items. Rows from SecondSetRow onwards run with node 127, TPDO1 base
  // 2047 (wraps to 0x07E), TPDO2 base 0x700 (so its id equals the guard reply id),
  // zero timeout and zero recovery period.
  step_row_t directed [22] = '{
    '{'{OP_STATE, 11'h000, 8'h00, 8'h00}, 1'b1,
      '{CMD_START, LINK_UNKNOWN, NodeCodeInit, 16'h0000}},
    '{'{OP_GUARD, 11'h7FF, 8'hFF, 8'hFF}, 1'b1,
      '{CMD_GUARD, LINK_UNKNOWN, NodeCodeInit, 16'h0000}},
    '{'{OP_NONE, 11'h7FF, 8'hFF, 8'hFF}, 1'b1,
      '{CMD_NONE, LINK_UNKNOWN, NodeCodeInit, 16'h0000}},
    '{'{OP_FRAME, 11'h701, 8'h85, 8'h00}, 1'b1,
      '{CMD_NONE, LINK_OPER, NodeCodeInit, 16'h0000}},
    '{'{OP_FRAME, 11'h181, 8'hFF, 8'hFF}, 1'b1,
      '{CMD_NONE, LINK_OPER, NodeCodeInit, 16'hFFFF}},
    '{'{OP_FRAME, 11'h281, 8'h34, 8'h12}, 1'b0, '0},
    '{'{OP_STATE, 11'h000, 8'h00, 8'h00}, 1'b1,
      '{CMD_NONE, LINK_OPER, NodeCodeReady, 16'h1234}},
    '{'{OP_FRAME, 11'h701, 8'h04, 8'h00}, 1'b1,
      '{CMD_NONE, LINK_STOPPED, NodeCodeReady, 16'h1234}},
    '{'{OP_STATE, 11'h5A5, 8'hA5, 8'h5A}, 1'b0, '0},
    '{'{OP_FRAME, 11'h701, 8'hFF, 8'h00}, 1'b0, '0},
    '{'{OP_FRAME, 11'h701, 8'h00, 8'h00}, 1'b0, '0},
    '{'{OP_FRAME, 11'h000, 8'h00, 8'h00}, 1'b0, '0},
    '{'{OP_GUARD, 11'h000, 8'h00, 8'h00}, 1'b1,
      '{CMD_GUARD, LINK_FAULT, NodeCodeInit, 16'h1234}},
    '{'{OP_STATE, 11'h000, 8'h00, 8'h00}, 1'b1,
      '{CMD_NONE, LINK_FAULT, NodeCodeEmerg, 16'h1234}},
    '{'{OP_STATE, 11'h000, 8'h00, 8'h00}, 1'b1,
      '{CMD_RESET, LINK_FAULT, NodeCodeEmerg, 16'h1234}},
    '{'{OP_FRAME, 11'h07E, 8'h00, 8'h80}, 1'b0, '0},
    '{'{OP_FRAME, 11'h77F, 8'h00, 8'h99}, 1'b0, '0},
    '{'{OP_FRAME, 11'h77F, 8'h05, 8'h11}, 1'b0, '0},
    '{'{OP_STATE, 11'h000, 8'h00, 8'h00}, 1'b0, '0},
    '{'{OP_FRAME, 11'h701, 8'h04, 8'h00}, 1'b0, '0},
    '{'{OP_GUARD, 11'h2AA, 8'h55, 8'hAA}, 1'b0, '0},
    '{'{OP_FRAME, 11'h07F, 8'hAA, 8'h55}, 1'b0, '0}
  };

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Applies one item to the supervisor state and returns the result it gives.
  function automatic cng_result_t supervise(input cng_item_t it);
    logic [10:0] reply_id;
    logic [10:0] pdo_a_id;
    logic [10:0] pdo_b_id;
    logic [6:0]  nmt;
    logic        nmt_known;
    cmd_t        cmd;
    cng_result_t r;
    reply_id  = GuardBaseId + {4'd0, cfg_now.node_id};
    pdo_a_id  = cfg_now.pdo1_base + {4'd0, cfg_now.node_id};
    pdo_b_id  = cfg_now.pdo2_base + {4'd0, cfg_now.node_id};
    nmt       = it.data_byte0[6:0];
    nmt_known = (nmt == NmtStopped) || (nmt == NmtOperational) || (nmt == NmtPreop);
    cmd       = CMD_NONE;
    case (it.opcode)
      OP_FRAME: begin
        if (it.frame_id == reply_id) begin
          reply_age_now = '0;
          if (nmt == NmtStopped) link_now = LINK_STOPPED;
          else if (nmt == NmtOperational) link_now = LINK_OPER;
          else if (nmt == NmtPreop) link_now = LINK_PREOP;
        end
        // A reply with an unrecognised state byte may still carry process data.
        if (!(it.frame_id == reply_id && nmt_known) &&
            (it.frame_id == pdo_a_id || it.frame_id == pdo_b_id))
          count_now = {it.data_byte1, it.data_byte0};
      end
      OP_GUARD: begin
        cmd = CMD_GUARD;
        if (reply_age_now != AgeMax) reply_age_now = reply_age_now + 16'd1;
        if (reply_age_now > cfg_now.guard_timeout_ticks) link_now = LINK_FAULT;
      end
      OP_STATE: begin
        case (node_now)
          NodeCodeInit: begin
            if (link_now == LINK_FAULT) node_now = NodeCodeEmerg;
            else if (link_now != LINK_OPER) cmd = CMD_START;
            else node_now = NodeCodeReady;
            reply_age_now = '0;
          end
          NodeCodeReady: begin
            if (link_now == LINK_FAULT) node_now = NodeCodeEmerg;
            else if (link_now != LINK_OPER) node_now = NodeCodeInit;
          end
          default: begin
            if (link_now != LINK_FAULT) begin
              node_now = NodeCodeInit;
            end else if (recover_now == cfg_now.recover_period) begin
              recover_now = '0;
              cmd = CMD_RESET;
            end else begin
              recover_now = recover_now + 16'd1;
            end
          end
        endcase
      end
      default: ;
    endcase
    r.command     = cmd;
    r.link_status = link_now;
    r.node_state  = node_now;
    r.count_value = count_now;
    return r;
  endfunction

  // Mostly well-formed traffic for the node as currently configured.
  function automatic cng_item_t draw_item();
    cng_item_t   it;
    int unsigned pick;
    it.opcode     = OP_NONE;
    it.frame_id   = 11'($urandom_range(0, 2047));
    it.data_byte0 = 8'($urandom_range(0, 255));
    it.data_byte1 = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      it.opcode   = OP_FRAME;
      it.frame_id = GuardBaseId + {4'd0, cfg_now.node_id};
      case ($urandom_range(0, 3))
        0: it.data_byte0[6:0] = NmtStopped;
        1: it.data_byte0[6:0] = NmtOperational;
        2: it.data_byte0[6:0] = NmtPreop;
        default: ;
      endcase
    end else if (pick < 24) begin
      it.opcode   = OP_FRAME;
      it.frame_id = ($urandom_range(0, 1) ? cfg_now.pdo1_base : cfg_now.pdo2_base) +
                    {4'd0, cfg_now.node_id};
    end else if (pick < 30) begin
      it.opcode = OP_FRAME;
    end else if (pick < 62) begin
      it.opcode = OP_GUARD;
    end else if (pick < 94) begin
      it.opcode = OP_STATE;
    end
    return it;
  endfunction

  // Offers one item in bursts separated by random gaps and waits until it is taken.
  task automatic offer(input cng_item_t it, input bit pinned, input cng_result_t want);
    fixed_q.push_back('{pinned, want});
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= it.opcode;
    in_ch.frame_id   <= it.frame_id;
    in_ch.data_byte0 <= it.data_byte0;
    in_ch.data_byte1 <= it.data_byte1;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic load_settings(input cng_cfg_t s);
    write_reg(CFG_NODE_ID, {9'd0, s.node_id});
    write_reg(CFG_PDO1_BASE, {5'd0, s.pdo1_base});
    write_reg(CFG_PDO2_BASE, {5'd0, s.pdo2_base});
    write_reg(CFG_GUARD_TIMEOUT, s.guard_timeout_ticks);
    write_reg(CFG_RECOVER_PERIOD, s.recover_period);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result receiver: spans of random duty, and one long hold-off on request.
  initial begin
    int unsigned duty;
    int unsigned span;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (64) @(posedge clk);
      end else begin
        duty = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(20, 95);
        span = $urandom_range(4, 40);
        repeat (span) begin
          res_ch.ready <= ($urandom_range(1, 100) <= duty);
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_now       = '{7'd1, 11'd384, 11'd640, 16'd15, 16'd40};
      link_now      = LINK_UNKNOWN;
      node_now      = NodeCodeInit;
      count_now     = '0;
      reply_age_now = '0;
      recover_now   = '0;
    end else begin
      // Results are taken first: one leaving now belongs to an earlier item.
      if (res_ch.valid && res_ch.ready) begin
        got_r = {res_ch.command, res_ch.link_status, res_ch.node_state, res_ch.count_value};
        if (due_results.size() == 0) begin
          $error("result item with nothing expected: command %0d count_value %0h",
                 got_r.command, got_r.count_value);
          mismatches++;
        end else begin
          want_r = due_results.pop_front();
          if (got_r.command !== want_r.command) begin
            $error("command: expected %0d, got %0d", want_r.command, got_r.command);
            mismatches++;
          end
          if (got_r.link_status !== want_r.link_status) begin
            $error("link_status: expected %0d, got %0d",
                   want_r.link_status, got_r.link_status);
            mismatches++;
          end
          if (got_r.node_state !== want_r.node_state) begin
            $error("node_state: expected %0d, got %0d", want_r.node_state, got_r.node_state);
            mismatches++;
          end
          if (got_r.count_value !== want_r.count_value) begin
            $error("count_value: expected %0h, got %0h",
                   want_r.count_value, got_r.count_value);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        taken_item  = {in_ch.opcode, in_ch.frame_id, in_ch.data_byte0, in_ch.data_byte1};
        tag         = (fixed_q.size() != 0) ? fixed_q.pop_front() : '0;
        predicted_r = supervise(taken_item);
        due_results.push_back(tag.pinned ? tag.want : predicted_r);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_NODE_ID:        cfg_now.node_id             = cfg_ch.data[6:0];
          CFG_PDO1_BASE:      cfg_now.pdo1_base           = cfg_ch.data[10:0];
          CFG_PDO2_BASE:      cfg_now.pdo2_base           = cfg_ch.data[10:0];
          CFG_GUARD_TIMEOUT:  cfg_now.guard_timeout_ticks = cfg_ch.data;
          CFG_RECOVER_PERIOD: cfg_now.recover_period      = cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  initial begin
    cng_cfg_t  s;
    cng_item_t it;
    int        n;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_NONE;
    in_ch.frame_id   <= '0;
    in_ch.data_byte0 <= '0;
    in_ch.data_byte1 <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_NODE_ID;
    cfg_ch.data      <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < $size(directed); n++) begin
      if (n == SecondSetRow) begin
        settle();
        load_settings('{7'd127, 11'd2047, GuardBaseId, 16'd0, 16'd0});
      end
      offer(directed[n].item, directed[n].pinned, directed[n].want);
    end

    for (int p = 0; p < RandomPhases; p++) begin
      settle();
      if (p == 0) begin
        s = '{7'd1, 11'd0, 11'd0, 16'd0, 16'd0};
      end else if (p == 1) begin
        s = '{7'd127, 11'd2047, 11'd2047, 16'hFFFF, 16'hFFFF};
      end else begin
        s.node_id             = 7'($urandom_range(1, 127));
        s.pdo1_base           = 11'($urandom_range(0, 2047));
        s.pdo2_base           = ($urandom_range(0, 3) == 0) ? s.pdo1_base
                                                            : 11'($urandom_range(0, 2047));
        s.guard_timeout_ticks = 16'($urandom_range(0, 6));
        s.recover_period      = 16'($urandom_range(0, 4));
      end
      load_settings(s);
      if (p == 2) squeeze_req = 1'b1;
      repeat (PhaseItems) offer(draw_item(), 1'b0, '0);
    end

    // Guard ticks under the largest timeout never force fault.
    settle();
    load_settings('{7'd5, 11'd384, 11'd640, 16'hFFFF, 16'hFFFF});
    offer('{OP_FRAME, GuardBaseId + 11'd5, 8'h05, 8'h00}, 1'b0, '0);
    repeat (LongRunItems) begin
      it = '{OP_GUARD, 11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255))};
      offer(it, 1'b0, '0);
    end

    // Enter emergency, build up a recovery count, then shrink the period below
    // it so that the count runs on past the period without a reset command.
    settle();
    load_settings('{7'd5, 11'd384, 11'd640, 16'd0, 16'hFFFF});
    offer('{OP_GUARD, 11'd0, 8'd0, 8'd0}, 1'b0, '0);
    repeat (12) offer('{OP_STATE, 11'd0, 8'd0, 8'd0}, 1'b0, '0);
    settle();
    load_settings('{7'd5, 11'd384, 11'd640, 16'd0, 16'd0});
    repeat (LongRunItems) offer('{OP_STATE, 11'd0, 8'd0, 8'd0}, 1'b0, '0);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < DrainLimit && due_results.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d result items never arrived", due_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
